/* sv/double_ended_ring_queue_top_defines.svh */
// Assertion macros for the double-ended ring queue.
// Used by the top level only; these macros expand to nothing in synthesis builds.
`ifndef DOUBLE_ENDED_RING_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_RING_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dq assertion failed");
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dq assertion failed");
`else
`define DQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/dq_pkg.sv */
// Shared types and codes for the double-ended ring queue.
// No dependencies; the front end, command queue, back end and top level import it.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int VAL_W = 32;
  localparam int OCC_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] entry;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic             listing;
    logic [OCC_W-1:0] occ;
  } bk_stat_t;

endpackage

/* sv/double_ended_ring_queue_top.sv */
// Double-ended ring queue of signed 32-bit values, DEPTH entries deep.
// Each item inserts at the front or back, removes from the front or back, or
// lists the contents front to back. An item passes a two-entry command queue
// and is then executed by the back end, giving one result; a listing of N
// entries gives N results at one per cycle while the output queue has room,
// paced by the single read port of the entry RAM, and the next command starts
// only once the last read has returned. Operation codes 5 to 7 are taken and
// produce no result. Results wait in a two-entry output queue, so with the
// command queue the input keeps flowing for a few items while a result is
// stalled. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "double_ended_ring_queue_top_defines.svh"
module double_ended_ring_queue_top import dq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              operation,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] entry,
  output logic                    last
);

  logic     fq_valid;
  logic     fq_ready;
  cmd_t     fq_cmd;
  logic     qb_valid;
  logic     qb_ready;
  cmd_t     qb_cmd;
  status_t  bk_status;
  bk_stat_t bk_stat;

  dq_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  dq_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  dq_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (bk_status),
    .entry     (entry),
    .last      (last),
    .stat      (bk_stat)
  );

  assign status = bk_status;

  // Error results are always single, final and carry no entry.
  `DQ_ASSERT_SAME(a_err_shape, clk, rst, out_valid && (bk_status != STAT_OK), last && (entry == '0))
  `DQ_ASSERT_SAME(a_occ_bound, clk, rst, 1'b1, bk_stat.occ <= OCC_W'(DEPTH))
  // A listing never changes the contents.
  `DQ_ASSERT_NEXT(a_list_stable, clk, rst, bk_stat.listing, $stable(bk_stat.occ))
  `DQ_ASSERT_SAME(a_list_busy, clk, rst, bk_stat.listing, !qb_ready)

endmodule

/* sv/dq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dq_front.sv */
// Front end: accepts input items, decodes the operation code and drops
// undefined codes. Depends on dq_pkg.
`timescale 1ns / 1ps
module dq_front import dq_pkg::*; (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              operation,
  input  logic signed [VAL_W-1:0] value,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output cmd_t                    cmd
);

  logic known;

  always_comb begin
    unique case (operation)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK, OP_LIST: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // Undefined codes are taken and dropped; they never reach the back end.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && known;
  assign cmd.op    = op_t'(operation);
  assign cmd.value = value;

endmodule

/* sv/dq_cmdq.sv */
// Two-entry command queue between the front and back ends.
// Depends on dq_pkg.
`timescale 1ns / 1ps
module dq_cmdq import dq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       head;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic       tail;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_cmd    = slots[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign tail       = head ^ cnt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_cmd;
    end
  end

endmodule

/* sv/dq_back.sv */
// Back end: owns the ring pointers and the entry RAM, executes commands and
// buffers results in a two-entry output queue. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
module dq_back import dq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  cmd_t                    cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output status_t                 status,
  output logic signed [VAL_W-1:0] entry,
  output logic                    last,
  output bk_stat_t                stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_LIST = 2'b10
  } state_t;

  function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  state_t        state, state_next;
  logic [PW-1:0] fp, fp_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] idx, idx_next;
  logic          inflight;
  logic          infl_last;

  logic              we;
  logic [PW-1:0]     waddr;
  logic [PW-1:0]     raddr;
  logic [VAL_W-1:0]  rdata;
  logic              issue;
  logic              issue_last;
  logic              direct_push;
  status_t           direct_status;

  res_t       oq [2];
  logic       oq_head;
  logic [1:0] oq_cnt;
  logic [1:0] used;
  logic       oq_pop;
  logic       oq_push;
  logic       oq_tail;
  logic       room;
  logic       full;
  logic       empty;
  res_t       push_res;

  assign out_valid = (oq_cnt != 2'd0);
  assign oq_pop    = out_valid && out_ready;
  assign used      = oq_cnt + {1'b0, inflight};
  // A slot must be free for any result that could land next cycle.
  assign room      = (used < 2'd2) || oq_pop;
  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);

  always_comb begin
    state_next    = state;
    fp_next       = fp;
    occ_next      = occ;
    idx_next      = idx;
    we            = 1'b0;
    waddr         = fp;
    raddr         = ring_add(fp, idx);
    issue         = 1'b0;
    issue_last    = (idx == occ - CW'(1));
    direct_push   = 1'b0;
    direct_status = STAT_OK;
    cmd_ready     = 1'b0;
    unique case (state)
      S_LIST: begin
        if (room) begin
          issue    = 1'b1;
          idx_next = idx + CW'(1);
          if (issue_last) begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (cmd_valid && !inflight && room) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              direct_push = 1'b1;
              if (full) begin
                direct_status = STAT_FULL;
              end else begin
                fp_next  = (fp == '0) ? PW'(DEPTH - 1) : fp - PW'(1);
                we       = 1'b1;
                waddr    = fp_next;
                occ_next = occ + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              direct_push = 1'b1;
              if (full) begin
                direct_status = STAT_FULL;
              end else begin
                we       = 1'b1;
                waddr    = ring_add(fp, occ);
                occ_next = occ + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              direct_push = 1'b1;
              if (empty) begin
                direct_status = STAT_EMPTY;
              end else begin
                fp_next  = ring_add(fp, CW'(1));
                occ_next = occ - CW'(1);
              end
            end
            OP_POP_BACK: begin
              direct_push = 1'b1;
              if (empty) begin
                direct_status = STAT_EMPTY;
              end else begin
                occ_next = occ - CW'(1);
              end
            end
            OP_LIST: begin
              if (empty) begin
                direct_push   = 1'b1;
                direct_status = STAT_EMPTY;
              end else begin
                state_next = S_LIST;
                idx_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_EXEC;
      end
    endcase
  end

  dq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_EXEC;
      fp       <= '0;
      occ      <= '0;
      idx      <= '0;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      fp       <= fp_next;
      occ      <= occ_next;
      idx      <= idx_next;
      inflight <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      infl_last <= issue_last;
    end
  end

  // Read data and direct results never land in the same cycle: a command
  // starts only once no read is outstanding.
  assign oq_push = inflight || direct_push;
  assign oq_tail = oq_head ^ oq_cnt[0];

  always_comb begin
    if (inflight) begin
      push_res.status = STAT_OK;
      push_res.entry  = rdata;
      push_res.last   = infl_last;
    end else begin
      push_res.status = direct_status;
      push_res.entry  = '0;
      push_res.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head <= 1'b0;
      oq_cnt  <= 2'd0;
    end else begin
      if (oq_pop) begin
        oq_head <= ~oq_head;
      end
      oq_cnt <= oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_tail] <= push_res;
    end
  end

  assign status       = oq[oq_head].status;
  assign entry        = oq[oq_head].entry;
  assign last         = oq[oq_head].last;
  assign stat.listing = (state == S_LIST);
  assign stat.occ     = OCC_W'(occ);

endmodule
